@@ rtl/tfi_pkg.sv @@
// ----------------------------------------------------------------------------
// tfi_pkg: shared types and constants for the thrust/friction integrator
// Operation codes, state reset values, the per-axis state record and the
// 32-bit saturation helper.
// ----------------------------------------------------------------------------
package tfi_pkg;

  // Operation codes carried by each input item
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_BUTTONS = 2'd1,
    OP_SENT    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic CFG_THRUST_GAIN    = 1'b0;
  localparam logic CFG_FRICTION_LIMIT = 1'b1;

  // Configuration reset values
  localparam logic [7:0] THRUST_GAIN_RST    = 8'd2;
  localparam logic [7:0] FRICTION_LIMIT_RST = 8'd1;

  // Saturation bounds, sized for the widened sums
  localparam logic signed [33:0] SUM_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SUM_MIN = -34'sd2147483648;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  // Position and velocity of one axis
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } axis_state_t;

  // Clamp a widened sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > SUM_MAX) begin
      r = WORD_MAX;
    end else if (v < SUM_MIN) begin
      r = WORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/thrust_friction_integrator_2d.sv @@
// ----------------------------------------------------------------------------
// thrust_friction_integrator_2d: 2D point driven by four direction buttons
// Path: an accepted input enters the input stage, then passes through the
//   update logic into the result register.
// Throughput: one item per cycle while out_ready does not stall the result register; in_ready follows out_ready.
// Reset: synchronous rst clears position, velocity, buttons, pending flag
//   and both stages; gain returns to 2 and friction limit to 1.
// ----------------------------------------------------------------------------
module thrust_friction_integrator_2d
  import tfi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic               left_pressed,
  input  logic               right_pressed,
  input  logic               up_pressed,
  input  logic               down_pressed,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic               needs_update
);

  logic [7:0]  thrust_gain;
  logic [7:0]  friction_limit;

  logic        stage_valid;
  op_t         stage_op;
  logic [3:0]  stage_buttons;

  logic [3:0]  button_flags;
  axis_state_t state_x;
  axis_state_t state_y;
  logic        pending;

  axis_state_t tick_x;
  axis_state_t tick_y;
  logic        advance;

  // Move the staged item into the result register when it is free
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thrust_gain    <= THRUST_GAIN_RST;
      friction_limit <= FRICTION_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRUST_GAIN:    thrust_gain    <= cfg_wdata;
        CFG_FRICTION_LIMIT: friction_limit <= cfg_wdata;
        default:            thrust_gain    <= thrust_gain;
      endcase
    end
  end

  // Capture an accepted item into the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_op      <= op_t'(operation);
      stage_buttons <= {down_pressed, up_pressed, right_pressed, left_pressed};
    end
  end

  // Per-axis tick update: x is right minus left, y is up minus down
  tfi_axis u_axis_x (
    .cur            (state_x),
    .pos_btn        (button_flags[1]),
    .neg_btn        (button_flags[0]),
    .thrust_gain    (thrust_gain),
    .friction_limit (friction_limit),
    .nxt            (tick_x)
  );

  tfi_axis u_axis_y (
    .cur            (state_y),
    .pos_btn        (button_flags[2]),
    .neg_btn        (button_flags[3]),
    .thrust_gain    (thrust_gain),
    .friction_limit (friction_limit),
    .nxt            (tick_y)
  );

  // Update state and load the result register
  axis_state_t state_x_next;
  axis_state_t state_y_next;
  logic [3:0]  button_flags_next;
  logic        pending_next;

  always_comb begin
    state_x_next      = state_x;
    state_y_next      = state_y;
    button_flags_next = button_flags;
    pending_next      = pending;
    case (stage_op)
      OP_TICK: begin
        state_x_next = tick_x;
        state_y_next = tick_y;
        if ((tick_x.pos != state_x.pos) || (tick_y.pos != state_y.pos)) begin
          pending_next = 1'b1;
        end
      end
      OP_BUTTONS: button_flags_next = stage_buttons;
      OP_SENT:    pending_next      = 1'b0;
      default:    pending_next      = pending;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_x      <= '0;
      state_y      <= '0;
      button_flags <= '0;
      pending      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        state_x      <= state_x_next;
        state_y      <= state_y_next;
        button_flags <= button_flags_next;
        pending      <= pending_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pos_x        <= state_x_next.pos;
      pos_y        <= state_y_next.pos;
      needs_update <= pending_next;
    end
  end

  // Checks
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready while result register is free");

  a_ack_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && stage_op == OP_SENT) |=> (out_valid && !needs_update))
    else $error("acknowledge did not clear pending flag");

  a_no_move_off_tick: assert property (@(posedge clk) disable iff (rst)
    (advance && stage_op != OP_TICK) |=> ($stable(state_x) && $stable(state_y)))
    else $error("position or velocity changed without a tick");

  a_move_sets_pending: assert property (@(posedge clk) disable iff (rst)
    (advance && stage_op == OP_TICK) ##1 (state_x.pos != $past(state_x.pos))
      |-> pending)
    else $error("position moved without setting pending flag");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (pos_x == state_x.pos && pos_y == state_y.pos
                 && needs_update == pending))
    else $error("result register disagrees with state");

endmodule

@@ rtl/tfi_axis.sv @@
// ----------------------------------------------------------------------------
// tfi_axis: one axis tick update
// Applies thrust, then friction toward zero, then integrates velocity into
// position, with saturation on the thrust and position sums.
// ----------------------------------------------------------------------------
module tfi_axis
  import tfi_pkg::*;
(
  input  axis_state_t cur,
  input  logic        pos_btn,
  input  logic        neg_btn,
  input  logic [7:0]  thrust_gain,
  input  logic [7:0]  friction_limit,
  output axis_state_t nxt
);

  logic signed [9:0]  thrust;
  logic signed [31:0] vel_thr;
  logic [31:0]        mag;
  logic [7:0]         fr;
  logic signed [31:0] fr_ext;
  logic signed [31:0] vel_new;

  // Pick thrust from the button pair; both held cancels
  always_comb begin
    if (pos_btn && !neg_btn) begin
      thrust = $signed({2'b00, thrust_gain});
    end else if (neg_btn && !pos_btn) begin
      thrust = -$signed({2'b00, thrust_gain});
    end else begin
      thrust = '0;
    end
  end

  // Add thrust with saturation
  assign vel_thr = sat32(34'(cur.vel) + 34'(thrust));

  // Magnitude, then friction capped at the magnitude
  assign mag    = vel_thr[31] ? 32'(-vel_thr) : 32'(vel_thr);
  assign fr     = (mag < {24'd0, friction_limit}) ? mag[7:0] : friction_limit;
  assign fr_ext = $signed({24'd0, fr});

  // Pull velocity toward zero without crossing it
  always_comb begin
    if (vel_thr > 32'sd0) begin
      vel_new = vel_thr - fr_ext;
    end else if (vel_thr < 32'sd0) begin
      vel_new = vel_thr + fr_ext;
    end else begin
      vel_new = '0;
    end
  end

  // Integrate position with saturation
  assign nxt.vel = vel_new;
  assign nxt.pos = sat32(34'(cur.pos) + 34'(vel_new));

endmodule
